@@ hw/rtl/nearest_palette_color_core_defines.svh @@
// Assertion macros shared by the nearest palette color core.
`ifndef NEAREST_PALETTE_COLOR_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on aclk and disabled during reset.
`define NPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk and disabled during reset.
`define NPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/npc_pkg.sv @@
// Shared constants and types of the nearest palette color core.
package npc_pkg;

    // Field widths and bus widths.
    localparam int COMP_W  = 16;
    localparam int SLOT_W  = 8;
    localparam int TAG_W   = 8;
    localparam int COUNT_W = 9;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 34;
    localparam int TDATA_W = 64;

    // Default palette depth.
    localparam int PALETTE_DEPTH_DEF = 256;

    // Reset value of the searched slot count.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // Largest component value and the starting distance bound.
    localparam logic [COMP_W-1:0] COMP_MAX = 16'hffff;
    localparam logic [DIST_W-1:0] START_BOUND =
        DIST_W'(3) * DIST_W'(COMP_MAX) * DIST_W'(COMP_MAX);

    // Request queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        action_t           action;
        logic [SLOT_W-1:0] slot;
        rgb_t              color;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic emitting;
    } bk_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_EMIT
    } bk_state_t;

endpackage

@@ hw/rtl/npc_front.sv @@
// Front part: accepts requests, decodes them and drops out-of-range writes.
module npc_front #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [npc_pkg::TDATA_W-1:0]  s_tdata,
    input  logic                         s_tuser,
    input  npc_pkg::q_stat_t             q_stat,
    output logic                         q_push,
    output npc_pkg::cmd_t                q_push_cmd
);
    import npc_pkg::*;

    logic hold_v_reg;
    logic hold_v_next;
    cmd_t hold_cmd_reg;
    cmd_t dec_cmd;
    logic accept;
    logic drop;

    // Unpack the request; tdata carries slot, red, green, blue and tag from the low bits up.
    always_comb begin
        dec_cmd.action      = action_t'(s_tuser);
        dec_cmd.slot        = s_tdata[7:0];
        dec_cmd.color.red   = s_tdata[23:8];
        dec_cmd.color.green = s_tdata[39:24];
        dec_cmd.color.blue  = s_tdata[55:40];
        dec_cmd.tag         = s_tdata[63:56];
    end

    // A write to a slot beyond the palette has no effect and is dropped here.
    assign drop = (dec_cmd.action == ACT_WRITE) && (32'(dec_cmd.slot) >= PALETTE_DEPTH);

    assign q_push     = hold_v_reg && q_stat.not_full;
    assign q_push_cmd = hold_cmd_reg;
    assign s_tready   = !hold_v_reg || q_stat.not_full;
    assign accept     = s_tvalid && s_tready;

    // Holding register occupancy.
    always_comb begin
        hold_v_next = hold_v_reg;
        if (accept) begin
            hold_v_next = !drop;
        end else if (q_push) begin
            hold_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
        end else begin
            hold_v_reg <= hold_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_cmd_reg <= dec_cmd;
        end
    end

endmodule

@@ hw/rtl/npc_queue.sv @@
// Short request queue that decouples the front and back parts.
module npc_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  npc_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output npc_pkg::cmd_t    head_cmd,
    output npc_pkg::q_stat_t stat
);
    import npc_pkg::*;

    cmd_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head_cmd       = slots_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/npc_back.sv @@
// Back part: palette memory, distance pipeline, best-match tracking and result register.
module npc_back #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [npc_pkg::COUNT_W-1:0]  palette_count,
    input  npc_pkg::q_stat_t             q_stat,
    input  npc_pkg::cmd_t                q_cmd,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [npc_pkg::TDATA_W-1:0]  m_tdata,
    output npc_pkg::bk_stat_t            stat
);
    import npc_pkg::*;

    localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                   input logic [COMP_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // Palette memory.
    rgb_t mem [PALETTE_DEPTH];
    rgb_t mem_q_reg;

    bk_state_t          state_reg;
    bk_state_t          state_next;
    cmd_t               query_reg;
    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] limit_reg;
    logic [COUNT_W-1:0] scan_n_reg;
    logic [COUNT_W-1:0] scan_idx_reg;
    logic               start;
    logic               issue;
    logic               out_load;

    // Read stage.
    logic               rd_v_reg;
    logic [COUNT_W-1:0] rd_idx_reg;
    logic               rd_elig_reg;
    logic               rd_first_reg;

    // Square stage.
    logic               sq_v_reg;
    logic [SQ_W-1:0]    sq_r_reg;
    logic [SQ_W-1:0]    sq_g_reg;
    logic [SQ_W-1:0]    sq_b_reg;
    rgb_t               sq_ent_reg;
    logic [COUNT_W-1:0] sq_idx_reg;
    logic               sq_elig_reg;
    logic               sq_first_reg;
    logic [COMP_W-1:0]  dr;
    logic [COMP_W-1:0]  dg;
    logic [COMP_W-1:0]  db;

    // Sum stage.
    logic               sum_v_reg;
    logic [DIST_W-1:0]  sum_dist_reg;
    rgb_t               sum_ent_reg;
    logic [COUNT_W-1:0] sum_idx_reg;
    logic               sum_elig_reg;
    logic               sum_first_reg;

    // Best match so far.
    logic [DIST_W-1:0]  best_dist_reg;
    logic [COUNT_W-1:0] best_idx_reg;
    rgb_t               best_rgb_reg;

    // Result register.
    logic               m_valid_reg;
    logic [TDATA_W-1:0] m_data_reg;

    // Searched count, saturated at the palette depth.
    assign limit = (32'(palette_count) > PALETTE_DEPTH) ? COUNT_W'(PALETTE_DEPTH)
                                                        : palette_count;

    // Sequencer: next state and control strobes.
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        start      = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_stat.not_empty) begin
                    q_pop = 1'b1;
                    if (q_cmd.action == ACT_QUERY) begin
                        start      = 1'b1;
                        state_next = BK_SCAN;
                    end
                end
            end
            BK_SCAN: begin
                issue = 1'b1;
                if (scan_idx_reg == scan_n_reg - COUNT_W'(1)) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (!rd_v_reg && !sq_v_reg && !sum_v_reg) begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Query latch and scan counter; slot zero is always read so its color is the fallback.
    always_ff @(posedge aclk) begin
        if (start) begin
            query_reg    <= q_cmd;
            limit_reg    <= limit;
            scan_n_reg   <= (limit == '0) ? COUNT_W'(1) : limit;
            scan_idx_reg <= '0;
        end else if (issue) begin
            scan_idx_reg <= scan_idx_reg + COUNT_W'(1);
        end
    end

    // Memory write port and registered read port.
    always_ff @(posedge aclk) begin
        if (q_pop && (q_cmd.action == ACT_WRITE)) begin
            mem[ADDR_W'(q_cmd.slot)] <= q_cmd.color;
        end
        if (issue) begin
            mem_q_reg <= mem[ADDR_W'(scan_idx_reg)];
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg  <= 1'b0;
            sq_v_reg  <= 1'b0;
            sum_v_reg <= 1'b0;
        end else begin
            rd_v_reg  <= issue;
            sq_v_reg  <= rd_v_reg;
            sum_v_reg <= sq_v_reg;
        end
    end

    assign dr = abs_diff(mem_q_reg.red,   query_reg.color.red);
    assign dg = abs_diff(mem_q_reg.green, query_reg.color.green);
    assign db = abs_diff(mem_q_reg.blue,  query_reg.color.blue);

    // Pipeline payload: read tags, squares, then the sum of squares.
    always_ff @(posedge aclk) begin
        rd_idx_reg    <= scan_idx_reg;
        rd_elig_reg   <= (scan_idx_reg < limit_reg);
        rd_first_reg  <= (scan_idx_reg == '0);

        sq_r_reg      <= SQ_W'(dr) * SQ_W'(dr);
        sq_g_reg      <= SQ_W'(dg) * SQ_W'(dg);
        sq_b_reg      <= SQ_W'(db) * SQ_W'(db);
        sq_ent_reg    <= mem_q_reg;
        sq_idx_reg    <= rd_idx_reg;
        sq_elig_reg   <= rd_elig_reg;
        sq_first_reg  <= rd_first_reg;

        sum_dist_reg  <= DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
        sum_ent_reg   <= sq_ent_reg;
        sum_idx_reg   <= sq_idx_reg;
        sum_elig_reg  <= sq_elig_reg;
        sum_first_reg <= sq_first_reg;
    end

    // Compare stage: only a strictly smaller distance replaces the best, so ties keep
    // the earlier slot.
    always_ff @(posedge aclk) begin
        if (sum_v_reg) begin
            if (sum_first_reg) begin
                best_idx_reg  <= sum_idx_reg;
                best_rgb_reg  <= sum_ent_reg;
                best_dist_reg <= (sum_elig_reg && (sum_dist_reg < START_BOUND)) ?
                                 sum_dist_reg : START_BOUND;
            end else if (sum_elig_reg && (sum_dist_reg < best_dist_reg)) begin
                best_idx_reg  <= sum_idx_reg;
                best_rgb_reg  <= sum_ent_reg;
                best_dist_reg <= sum_dist_reg;
            end
        end
    end

    // Result register; it frees as soon as the receiver takes the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {query_reg.tag, best_rgb_reg.blue, best_rgb_reg.green,
                           best_rgb_reg.red, best_idx_reg[SLOT_W-1:0]};
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = m_data_reg;
    assign stat.busy     = (state_reg != BK_IDLE);
    assign stat.emitting = out_load;

endmodule

@@ hw/rtl/nearest_palette_color_core.sv @@
// Top level of the nearest palette color core.
//
// Requests enter on the s_ stream. s_tuser selects the kind: a write stores the
// color in tdata into the palette slot given there, a query searches the palette
// for the entry closest to its color in squared RGB distance and answers on the
// m_ stream with the slot, that entry's color and the query's tag. On equal
// distances the lower slot wins. Writes give no result.
// cfg_wr_en with cfg_wr_data sets how many slots a query searches, from slot zero;
// it is to be written only while the core is idle; the core does not enforce this.
// A query occupies the search engine while it reads its count of slots, saturated
// at the palette depth and raised to at least one, one palette slot per cycle
// through the single memory read port, then while the pipeline drains and the
// result is loaded. A write is stored when it is popped and leaves the engine idle.
// A two-entry queue lets the input keep taking requests while a
// search runs. The result waits in an output register while m_tready is low and
// the engine stalls only when its next result finds that register still full.
// Reset clears the queue, the engine and the output register and sets the count to
// 256; palette contents are undefined until written.
`include "nearest_palette_color_core_defines.svh"

module nearest_palette_color_core #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // slot[7:0], red[23:8], green[39:24], blue[55:40], tag[63:56]
    input  logic [npc_pkg::TDATA_W-1:0]  s_tdata,
    // action[0]
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // match_slot[7:0], match_red[23:8], match_green[39:24], match_blue[55:40],
    // match_tag[63:56]
    output logic [npc_pkg::TDATA_W-1:0]  m_tdata,
    input  logic                         cfg_wr_en,
    input  logic [npc_pkg::COUNT_W-1:0]  cfg_wr_data
);
    import npc_pkg::*;

    logic [COUNT_W-1:0] palette_count_reg;
    q_stat_t            q_stat;
    logic               q_push;
    cmd_t               q_push_cmd;
    logic               q_pop;
    cmd_t               q_head_cmd;
    bk_stat_t           bk_stat;

    // Searched slot count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_count_reg <= COUNT_RESET;
        end else if (cfg_wr_en) begin
            palette_count_reg <= cfg_wr_data;
        end
    end

    npc_front #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_push_cmd (q_push_cmd)
    );

    npc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head_cmd (q_head_cmd),
        .stat     (q_stat)
    );

    npc_back #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .palette_count (palette_count_reg),
        .q_stat        (q_stat),
        .q_cmd         (q_head_cmd),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .stat          (bk_stat)
    );

    // The engine only takes a request that is present and only while it is free.
    `NPC_ASSERT_NOW(a_pop_not_empty, q_pop, q_stat.not_empty, "queue popped while empty")
    `NPC_ASSERT_NOW(a_pop_when_idle, q_pop, !bk_stat.busy, "queue popped while engine busy")
    // The front never pushes into a full queue.
    `NPC_ASSERT_NOW(a_push_not_full, q_push, q_stat.not_full, "queue pushed while full")
    // A popped query starts a search on the next cycle.
    `NPC_ASSERT_NEXT(a_query_starts, q_pop && (q_head_cmd.action == ACT_QUERY),
                     bk_stat.busy, "query popped but engine did not start")
    // A loaded result is offered on the next cycle.
    `NPC_ASSERT_NEXT(a_result_offered, bk_stat.emitting, m_tvalid, "result not offered")

endmodule
